[hdl/assert_macros.svh]
// assertion macros shared by the rtl of the frame builder
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/cfcb_pkg.sv]
// types, constants and helper functions of the command frame builder
// no dependencies
package cfcb_pkg;

   // field widths
   localparam int PAYLOAD_LEN_W = 13;
   localparam int STEP_W        = 6;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   // frame constants
   localparam logic [PAYLOAD_LEN_W-1:0] MAX_PAYLOAD = 13'd4096;
   localparam logic [15:0]              HDR_LEN     = 16'd42;
   localparam logic [15:0]              CRC_LEN     = 16'd2;
   localparam logic [15:0]              CRC_INIT    = 16'hFFFF;
   localparam logic [15:0]              CMD_RESET   = 16'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-3:0] REG_COMMAND = 1'b0;

   // item kinds
   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // byte positions within the emitted sequence
   localparam logic [STEP_W-1:0] STEP_TOTAL0   = 6'd0;
   localparam logic [STEP_W-1:0] STEP_PROV0    = 6'd4;
   localparam logic [STEP_W-1:0] STEP_SEC0     = 6'd20;
   localparam logic [STEP_W-1:0] STEP_CMD_LO   = 6'd36;
   localparam logic [STEP_W-1:0] STEP_CMD_HI   = 6'd37;
   localparam logic [STEP_W-1:0] STEP_LEN0     = 6'd38;
   localparam logic [STEP_W-1:0] STEP_HDR_LAST = 6'd41;
   localparam logic [STEP_W-1:0] STEP_PAYLOAD  = 6'd42;
   localparam logic [STEP_W-1:0] STEP_CRC_LO   = 6'd43;
   localparam logic [STEP_W-1:0] STEP_CRC_HI   = 6'd44;

   typedef struct packed {
      logic                     kind;
      logic [PAYLOAD_LEN_W-1:0] payload_length;
      logic [7:0]               payload_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
   } rsp_payload_type;

   // fixed provider field (0..15) and secure-code field (16..31)
   function automatic logic [7:0] hdr_const(input logic [4:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:    b = 8'h77;
         5'd1:    b = 8'h6F;
         5'd2:    b = 8'h6F;
         5'd3:    b = 8'h72;
         5'd4:    b = 8'h69;
         5'd5:    b = 8'h6E;
         5'd6:    b = 8'h65;
         5'd7:    b = 8'h74;
         5'd16:   b = 8'h57;
         5'd17:   b = 8'h33;
         5'd18:   b = 8'h35;
         5'd19:   b = 8'h33;
         5'd20:   b = 8'h33;
         5'd21:   b = 8'h37;
         5'd22:   b = 8'h33;
         5'd23:   b = 8'h39;
         5'd24:   b = 8'h36;
         5'd25:   b = 8'h31;
         5'd26:   b = 8'h32;
         5'd27:   b = 8'h36;
         5'd28:   b = 8'h39;
         5'd29:   b = 8'h36;
         5'd30:   b = 8'h39;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // one byte of reflected crc-16 0x1021
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] x;
      x = b ^ crc[7:0];
      x = x ^ {x[3:0], 4'b0};
      return {8'h00, crc[15:8]} ^ {x, 8'h00} ^ {5'b0, x, 3'b0} ^ {12'b0, x[7:4]};
   endfunction

endpackage

[hdl/crc_framed_command_builder_top.sv]
// Command frame builder: one byte of the outgoing frame per cycle on the rsp
// channel while rsp_stall is low. A start transaction emits the 42 header bytes,
// followed by the CRC bytes when the payload length is zero; a payload byte
// emits one byte, followed by the CRC bytes when it ends the frame. Every byte
// passes through the single output byte register, and a new req transaction is
// taken in the cycle the last byte of the current one moves into it, so payload
// bytes stream at one per cycle while rsp_stall is low. A payload byte with no
// frame open is dropped without occupying the block. Lengths above 4096
// saturate. Depends on cfcb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module crc_framed_command_builder_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  cfcb_pkg::req_payload_type             req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output cfcb_pkg::rsp_payload_type             rsp_payload,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [cfcb_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [cfcb_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [cfcb_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   // configuration register
   logic [15:0] cmd_ff, cmd_in;
   logic        csr_wr, csr_hit;

   // frame tracking, updated at accept
   logic                               open_ff, open_in;
   logic [cfcb_pkg::PAYLOAD_LEN_W-1:0] rem_ff, rem_in;

   // current transaction being emitted
   logic                               busy_ff, busy_in;
   logic                               kind_ff, kind_in;
   logic                               last_ff, last_in;
   logic [cfcb_pkg::PAYLOAD_LEN_W-1:0] len_ff, len_in;
   logic [7:0]                         pbyte_ff, pbyte_in;
   logic [cfcb_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [15:0]                        crc_ff, crc_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_end_ff, rsp_end_in;

   logic                               out_adv, gen_fire, gen_last, req_accept, emits;
   logic [cfcb_pkg::PAYLOAD_LEN_W-1:0] len_sat;
   logic [31:0]                        total_w, len_w;
   logic [cfcb_pkg::STEP_W-1:0]        len_idx, const_idx;
   logic [7:0]                         gen_byte;
   logic [15:0]                        crc_base;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[cfcb_pkg::CSR_ADDR_W-1:2] == cfcb_pkg::REG_COMMAND);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_hit ? {16'h0000, cmd_ff} : '0;

   always_comb begin
      cmd_in = cmd_ff;
      if (csr_wr && csr_hit) begin
         cmd_in = csr_pwdata[15:0];
      end
   end

   // handshake
   assign out_adv    = !rsp_valid_ff || !rsp_stall;
   assign gen_fire   = busy_ff && out_adv;
   assign req_stall  = busy_ff && !(gen_fire && gen_last);
   assign req_accept = req_valid && !req_stall;

   // end of the current transaction
   always_comb begin
      gen_last = 1'b0;
      if (step_ff == cfcb_pkg::STEP_CRC_HI) begin
         gen_last = 1'b1;
      end else if ((step_ff == cfcb_pkg::STEP_HDR_LAST) || (step_ff == cfcb_pkg::STEP_PAYLOAD)) begin
         gen_last = !last_ff;
      end
   end

   // length saturation and frame state at accept
   assign len_sat = (req_payload.payload_length > cfcb_pkg::MAX_PAYLOAD) ?
                    cfcb_pkg::MAX_PAYLOAD : req_payload.payload_length;
   assign emits   = (req_payload.kind == cfcb_pkg::KIND_START) || (open_ff && (rem_ff != '0));

   always_comb begin
      open_in  = open_ff;
      rem_in   = rem_ff;
      busy_in  = busy_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      len_in   = len_ff;
      pbyte_in = pbyte_ff;
      if (gen_fire && gen_last) begin
         busy_in = 1'b0;
      end
      if (req_accept) begin
         busy_in  = emits;
         kind_in  = req_payload.kind;
         pbyte_in = req_payload.payload_byte;
         if (req_payload.kind == cfcb_pkg::KIND_START) begin
            len_in  = len_sat;
            last_in = (len_sat == '0);
            open_in = (len_sat != '0);
            rem_in  = len_sat;
         end else if (emits) begin
            last_in = (rem_ff == cfcb_pkg::PAYLOAD_LEN_W'(1));
            open_in = (rem_ff != cfcb_pkg::PAYLOAD_LEN_W'(1));
            rem_in  = rem_ff - cfcb_pkg::PAYLOAD_LEN_W'(1);
         end
      end
   end

   // byte for the current step
   assign total_w   = 32'(cfcb_pkg::HDR_LEN + cfcb_pkg::CRC_LEN + 16'(len_ff));
   assign len_w     = 32'(len_ff);
   assign len_idx   = step_ff - cfcb_pkg::STEP_LEN0;
   assign const_idx = step_ff - cfcb_pkg::STEP_PROV0;

   always_comb begin
      case (step_ff) inside
         [cfcb_pkg::STEP_TOTAL0:cfcb_pkg::STEP_PROV0 - 6'd1]:
            gen_byte = total_w[{step_ff[1:0], 3'b000} +: 8];
         [cfcb_pkg::STEP_PROV0:cfcb_pkg::STEP_CMD_LO - 6'd1]:
            gen_byte = cfcb_pkg::hdr_const(const_idx[4:0]);
         cfcb_pkg::STEP_CMD_LO:  gen_byte = cmd_ff[7:0];
         cfcb_pkg::STEP_CMD_HI:  gen_byte = cmd_ff[15:8];
         [cfcb_pkg::STEP_LEN0:cfcb_pkg::STEP_HDR_LAST]:
            gen_byte = len_w[{len_idx[1:0], 3'b000} +: 8];
         cfcb_pkg::STEP_PAYLOAD: gen_byte = pbyte_ff;
         cfcb_pkg::STEP_CRC_LO:  gen_byte = ~crc_ff[7:0];
         cfcb_pkg::STEP_CRC_HI:  gen_byte = ~crc_ff[15:8];
         default:                gen_byte = 8'h00;
      endcase
   end

   // step sequencing and crc update
   assign crc_base = (step_ff == cfcb_pkg::STEP_TOTAL0) ? cfcb_pkg::CRC_INIT : crc_ff;

   always_comb begin
      step_in = step_ff;
      crc_in  = crc_ff;
      if (gen_fire) begin
         if (step_ff <= cfcb_pkg::STEP_PAYLOAD) begin
            crc_in = cfcb_pkg::crc_feed(crc_base, gen_byte);
         end else if (step_ff == cfcb_pkg::STEP_CRC_HI) begin
            crc_in = cfcb_pkg::CRC_INIT;
         end
         if ((step_ff == cfcb_pkg::STEP_HDR_LAST) && last_ff) begin
            step_in = cfcb_pkg::STEP_CRC_LO;
         end else begin
            step_in = step_ff + 6'd1;
         end
      end
      if (req_accept) begin
         step_in = (req_payload.kind == cfcb_pkg::KIND_START) ?
                   cfcb_pkg::STEP_TOTAL0 : cfcb_pkg::STEP_PAYLOAD;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      if (out_adv) begin
         rsp_valid_in = gen_fire;
         rsp_byte_in  = gen_byte;
         rsp_end_in   = (step_ff == cfcb_pkg::STEP_CRC_HI);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_payload.out_byte  = rsp_byte_ff;
   assign rsp_payload.frame_end = rsp_end_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= cfcb_pkg::CMD_RESET;
         open_ff      <= 1'b0;
         rem_ff       <= '0;
         busy_ff      <= 1'b0;
         step_ff      <= cfcb_pkg::STEP_TOTAL0;
         crc_ff       <= cfcb_pkg::CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_ff       <= cmd_in;
         open_ff      <= open_in;
         rem_ff       <= rem_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      last_ff     <= last_in;
      len_ff      <= len_in;
      pbyte_ff    <= pbyte_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   // checks
   `ASSERT_IMPLY(a_accept_only_at_end, clock, reset, req_accept && busy_ff, gen_fire && gen_last)
   `ASSERT_IMPLY(a_step_in_range, clock, reset, busy_ff, step_ff <= cfcb_pkg::STEP_CRC_HI)
   `ASSERT_NEXT(a_start_begins_header, clock, reset,
      req_accept && (req_payload.kind == cfcb_pkg::KIND_START),
      busy_ff && (step_ff == cfcb_pkg::STEP_TOTAL0))
   `ASSERT_NEXT(a_crc_hi_ends_frame, clock, reset,
      gen_fire && (step_ff == cfcb_pkg::STEP_CRC_HI), rsp_valid_ff && rsp_end_ff)
   `ASSERT_IMPLY(a_payload_kind_step, clock, reset,
      busy_ff && (kind_ff == cfcb_pkg::KIND_PAYLOAD), step_ff >= cfcb_pkg::STEP_PAYLOAD)

endmodule
